FILE: hdl/tun_pkg.sv
// Shared types and constants for the triangle unit normal pipeline.
package tun_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned EdgeW  = 17;
  localparam int unsigned CrossW = 35;
  localparam int unsigned MagW   = 30;
  localparam int unsigned SumW   = 62;
  localparam int unsigned RootW  = 31;
  localparam int unsigned QuotW  = 15;
  localparam int unsigned NormW  = 16;
  localparam int unsigned InW    = 9 * CoordW;
  localparam int unsigned OutW   = 56;
  localparam logic [QuotW-1:0] QOne = 15'd16384;

  // Per-item sideband that travels with the normalized magnitudes.
  typedef struct packed {
    logic       degen;
    logic [2:0] neg;
  } side_t;

endpackage

FILE: hdl/triangle_unit_normal.sv
// Top level of the triangle unit normal pipeline.
//
//  Channel  Direction  Handshake                 Content
//  s_axis   in         s_axis_tvalid/tready      one triangle, nine Q8.8 coordinates
//  m_axis   out        m_axis_tvalid/tready      Q1.14 unit normal and degenerate flag
//
// One word enters every cycle while the output is not stalled; the depth of the pipeline
// is set by the 31-stage square root and the 16-stage dividers.
// The whole pipeline advances only while the output register is empty or being taken,
// so a stall holds every stage in place and nothing is lost or repeated.
// Reset clears only the valid bits; the data registers are not reset.
module triangle_unit_normal (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [tun_pkg::InW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // norm_x, norm_y, norm_z, degenerate, 7 zero bits
  output logic [tun_pkg::OutW-1:0] m_axis_tdata
);
  import tun_pkg::*;

  logic             en;
  logic             v1, v2;
  side_t            s1, s2;
  logic [MagW-1:0]  m1 [3], m2 [3];
  logic [RootW-1:0] root;

  // The pipeline moves when its final register is free or being drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  tun_cross u_cross (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .data_i(s_axis_tdata),
    .valid_o(v1), .side_o(s1), .mag_o(m1)
  );

  tun_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .side_i(s1), .mag_i(m1),
    .valid_o(v2), .side_o(s2), .mag_o(m2), .root_o(root)
  );

  tun_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .side_i(s2), .mag_i(m2), .root_i(root),
    .valid_o(m_axis_tvalid), .data_o(m_axis_tdata)
  );
endmodule

FILE: hdl/tun_cross.sv
// Edge vectors, cross product and block normalization, as two register stages.
module tun_cross (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [tun_pkg::InW-1:0]   data_i,
  output logic                      valid_o,
  output tun_pkg::side_t            side_o,
  output logic [tun_pkg::MagW-1:0]  mag_o [3]
);
  import tun_pkg::*;

  logic signed [CoordW-1:0] crd [9];
  logic signed [EdgeW-1:0]  ux, uy, uz, vx, vy, vz;
  logic signed [CrossW-1:0] p_d [6], p_q [6];
  logic signed [CrossW-1:0] n [3];
  logic [CrossW-2:0]        m [3];
  logic [CrossW-2:0]        mx;
  logic [5:0]               lz;
  logic                     v1_q, v2_q;
  side_t                    side_d, side_q;
  logic [MagW-1:0]          mag_d [3], mag_q [3];

  always_comb begin
    for (int i = 0; i < 9; i++) crd[i] = data_i[i*CoordW +: CoordW];
    ux = EdgeW'(crd[6]) - EdgeW'(crd[0]);
    uy = EdgeW'(crd[7]) - EdgeW'(crd[1]);
    uz = EdgeW'(crd[8]) - EdgeW'(crd[2]);
    vx = EdgeW'(crd[3]) - EdgeW'(crd[0]);
    vy = EdgeW'(crd[4]) - EdgeW'(crd[1]);
    vz = EdgeW'(crd[5]) - EdgeW'(crd[2]);
    p_d[0] = CrossW'(uy * vz);
    p_d[1] = CrossW'(uz * vy);
    p_d[2] = CrossW'(uz * vx);
    p_d[3] = CrossW'(ux * vz);
    p_d[4] = CrossW'(ux * vy);
    p_d[5] = CrossW'(uy * vx);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n[i] = p_q[2*i] - p_q[2*i+1];
      m[i] = n[i][CrossW-1] ? (CrossW-1)'(-n[i]) : n[i][CrossW-2:0];
    end
    mx = m[0] | m[1] | m[2];
    lz = 6'd0;
    for (int b = 0; b < CrossW - 1; b++) if (mx[b]) lz = 6'(CrossW - 2 - b);
    side_d.degen = (mx == '0);
    for (int i = 0; i < 3; i++) side_d.neg[i] = n[i][CrossW-1];
    // Shift so the largest magnitude lands in [2^29, 2^30).
    for (int i = 0; i < 3; i++) begin
      if (lz >= 6'd4) mag_d[i] = MagW'(m[i] << (lz - 6'd4));
      else            mag_d[i] = MagW'(m[i] >> (6'd4 - lz));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      side_q <= side_d;
      mag_q  <= mag_d;
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;
  assign mag_o   = mag_q;
endmodule

FILE: hdl/tun_sqrt.sv
// Sum of squares then a pipelined restoring square root, one result bit per stage.
module tun_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  tun_pkg::side_t            side_i,
  input  logic [tun_pkg::MagW-1:0]  mag_i [3],
  output logic                      valid_o,
  output tun_pkg::side_t            side_o,
  output logic [tun_pkg::MagW-1:0]  mag_o [3],
  output logic [tun_pkg::RootW-1:0] root_o
);
  import tun_pkg::*;

  localparam int unsigned Steps = RootW;

  logic [SumW-1:0]  sq_q [3];
  logic             vs_q;
  side_t            ss_q;
  logic [MagW-1:0]  ms_q [3];

  logic             v_q [Steps+1];
  side_t            s_q [Steps+1];
  logic [MagW-1:0]  m_q [Steps+1][3];
  logic [SumW-1:0]  x_q [Steps+1];
  logic [RootW-1:0] r_q [Steps+1];
  logic [SumW-1:0]  x_d [Steps];
  logic [RootW-1:0] r_d [Steps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= 1'b0;
      for (int k = 0; k <= Steps; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      vs_q   <= valid_i;
      v_q[0] <= vs_q;
      for (int k = 0; k < Steps; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      logic [SumW+1:0] trial;
      logic [SumW+1:0] rem;
      // rem holds the remaining radicand, the root grows one bit per step.
      rem   = {2'b00, x_q[k]};
      trial = (SumW+2)'({r_q[k], 2'b01}) << (2 * (Steps - 1 - k));
      if (rem >= trial) begin
        x_d[k] = SumW'(rem - trial);
        r_d[k] = {r_q[k][RootW-2:0], 1'b1};
      end else begin
        x_d[k] = x_q[k];
        r_d[k] = {r_q[k][RootW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) sq_q[i] <= SumW'(mag_i[i]) * SumW'(mag_i[i]);
      ss_q   <= side_i;
      ms_q   <= mag_i;
      x_q[0] <= sq_q[0] + sq_q[1] + sq_q[2];
      r_q[0] <= '0;
      s_q[0] <= ss_q;
      m_q[0] <= ms_q;
      for (int k = 0; k < Steps; k++) begin
        x_q[k+1] <= x_d[k];
        r_q[k+1] <= r_d[k];
        s_q[k+1] <= s_q[k];
        m_q[k+1] <= m_q[k];
      end
    end
  end

  assign valid_o = v_q[Steps];
  assign side_o  = s_q[Steps];
  assign mag_o   = m_q[Steps];
  assign root_o  = r_q[Steps];
endmodule

FILE: hdl/tun_div.sv
// Three pipelined restoring dividers giving rounded Q1.14 magnitudes, then sign and clamp.
module tun_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  tun_pkg::side_t            side_i,
  input  logic [tun_pkg::MagW-1:0]  mag_i [3],
  input  logic [tun_pkg::RootW-1:0] root_i,
  output logic                      valid_o,
  output logic [tun_pkg::OutW-1:0]  data_o
);
  import tun_pkg::*;

  // Dividend is below 2^45; the quotient never exceeds 2^14 + 1, within the 16 quotient bits.
  localparam int unsigned DivW  = 46;
  localparam int unsigned QBits = 16;

  logic             v_q [QBits+1];
  side_t            s_q [QBits+1];
  logic [RootW-1:0] l_q [QBits+1];
  logic [DivW-1:0]  n_q [QBits+1][3];
  logic [QBits-1:0] q_q [QBits+1][3];
  logic [DivW-1:0]  n_d [QBits][3];
  logic [QBits-1:0] q_d [QBits][3];
  logic             vo_q;
  logic [OutW-1:0]  do_q, do_d;

  always_comb begin
    for (int k = 0; k < QBits; k++) begin
      for (int i = 0; i < 3; i++) begin
        logic [DivW+QBits-1:0] dd;
        dd = (DivW+QBits)'(l_q[k]) << (QBits - 1 - k);
        if ((DivW+QBits)'(n_q[k][i]) >= dd) begin
          n_d[k][i] = n_q[k][i] - DivW'(dd);
          q_d[k][i] = {q_q[k][i][QBits-2:0], 1'b1};
        end else begin
          n_d[k][i] = n_q[k][i];
          q_d[k][i] = {q_q[k][i][QBits-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    do_d = '0;
    for (int i = 0; i < 3; i++) begin
      logic [QuotW-1:0] q;
      logic [NormW-1:0] s;
      q = (q_q[QBits][i] > 16'(QOne)) ? QOne : q_q[QBits][i][QuotW-1:0];
      s = s_q[QBits].neg[i] ? NormW'(-{1'b0, q}) : NormW'(q);
      if (s_q[QBits].degen) s = '0;
      do_d[i*NormW +: NormW] = s;
    end
    do_d[3*NormW] = s_q[QBits].degen;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QBits; k++) v_q[k] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 0; k < QBits; k++) v_q[k+1] <= v_q[k];
      vo_q <= v_q[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q[0] <= side_i;
      l_q[0] <= (root_i == '0) ? RootW'(1) : root_i;
      for (int i = 0; i < 3; i++) begin
        n_q[0][i] <= (DivW'(mag_i[i]) << 14) + DivW'(root_i >> 1);
        q_q[0][i] <= '0;
      end
      for (int k = 0; k < QBits; k++) begin
        s_q[k+1] <= s_q[k];
        l_q[k+1] <= l_q[k];
        n_q[k+1] <= n_d[k];
        q_q[k+1] <= q_d[k];
      end
      do_q <= do_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = do_q;
endmodule

FILE: hdl/tun_checker.sv
// Port-level checks for the triangle unit normal pipeline, bound to the top level.
module tun_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [tun_pkg::OutW-1:0] m_axis_tdata
);
  import tun_pkg::*;

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3*NormW] |-> m_axis_tdata[3*NormW-1:0] == '0)
    else $error("degenerate result carries a normal");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OutW-1:3*NormW+1] == '0)
    else $error("padding bits set");
endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
